[rtl/core/planar_odometry_integrator_unit_assert.svh]
// ----------------------------------------------------------------------------
// planar odometry integrator assertion macros
// immediate-cycle and next-cycle property checks on clk with rst_n disable
// ----------------------------------------------------------------------------
`ifndef PLANAR_ODOMETRY_INTEGRATOR_UNIT_ASSERT_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define POI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define POI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/poi_pkg.sv]
// ----------------------------------------------------------------------------
// poi_pkg
// types, codes and constants of the planar odometry integrator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package poi_pkg;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] linear_velocity;
    logic signed [31:0] angular_velocity;
    logic [47:0]        timestamp;
  } poi_in_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [31:0] heading;
  } poi_out_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ZERO   = 2'd1,
    OP_START  = 2'd2
  } poi_op_t;

  typedef enum logic [1:0] {
    REG_METHOD       = 2'd0,
    REG_INIT_X       = 2'd1,
    REG_INIT_Y       = 2'd2,
    REG_INIT_HEADING = 2'd3
  } poi_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_FIN,
    S_ANG,
    S_RED,
    S_FOLD,
    S_CORDIC,
    S_DONE
  } poi_state_t;

  typedef enum logic [1:0] {
    MK_DTH,
    MK_DIST,
    MK_DX,
    MK_DY
  } poi_mul_t;

  localparam logic [35:0]        TWO_PI_Q24  = 36'd105414357;
  localparam logic signed [29:0] TWO_PI_R    = 30'sd105414357;
  localparam logic signed [29:0] PI_R        = 30'sd52707179;
  localparam logic signed [29:0] HALF_PI_R   = 30'sd26353589;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [3:0]         RED_TOP     = 4'd8;
  localparam logic [95:0]        LIM_33      = 96'd1 << 33;
  localparam logic [95:0]        LIM_62      = 96'd1 << 62;

  function automatic logic [31:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:  return 32'h3243F6A8;
      5'd1:  return 32'h1DAC6705;
      5'd2:  return 32'h0FADBAFC;
      5'd3:  return 32'h07F56EA6;
      5'd4:  return 32'h03FEAB76;
      5'd5:  return 32'h01FFD55B;
      5'd6:  return 32'h00FFFAAA;
      5'd7:  return 32'h007FFF55;
      5'd8:  return 32'h003FFFEA;
      5'd9:  return 32'h001FFFFD;
      5'd10: return 32'h000FFFFF;
      5'd11: return 32'h0007FFFF;
      5'd12: return 32'h0003FFFF;
      5'd13: return 32'h0001FFFF;
      5'd14: return 32'h0000FFFF;
      5'd15: return 32'h00007FFF;
      5'd16: return 32'h00003FFF;
      5'd17: return 32'h00001FFF;
      5'd18: return 32'h00000FFF;
      5'd19: return 32'h000007FF;
      5'd20: return 32'h000003FF;
      5'd21: return 32'h000001FF;
      5'd22: return 32'h000000FF;
      5'd23: return 32'h0000007F;
      5'd24: return 32'h0000003F;
      5'd25: return 32'h0000001F;
      5'd26: return 32'h0000000F;
      5'd27: return 32'h00000008;
      5'd28: return 32'h00000004;
      5'd29: return 32'h00000002;
      5'd30: return 32'h00000001;
      default: return 32'h00000000;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return $signed(v[31:0]);
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/planar_odometry_integrator_unit.sv]
// ----------------------------------------------------------------------------
// planar_odometry_integrator_unit
// unicycle dead-reckoning pose integrator, euler or midpoint step, cordic trig
// ----------------------------------------------------------------------------
// A velocity sample word (op 0) holds the input off until its pose is handed
// to the output, so the block takes no new word while a sample is in work:
// the four products w*dt, v*dt, d*cos and d*sin each pass the states S_MUL_LO,
// S_MUL_HI and S_MUL_FIN on one shared 32x32 multiplier used in two passes,
// the angle reduction modulo 2pi makes nine compare-subtract steps, the
// CORDIC rotation loop runs one iteration per cycle, and the angle setup, the
// fold and the hand-off to the output are states of their own. The pose lands
// in an output register, so the next word is taken while a result still
// waits; a second finished pose waits inside until the first one is taken and
// the input stays off meanwhile. Zero and start words leave the block idle and
// give no result. Configuration writes take effect at the next edge and belong
// between words, while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
`include "planar_odometry_integrator_unit_assert.svh"

module planar_odometry_integrator_unit
  import poi_pkg::*;
#(
  parameter int CORDIC_STEPS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire poi_in_t     in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output poi_out_t         out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam logic [4:0] STEP_LAST = 5'(CORDIC_STEPS - 1);

  poi_state_t state_r, state_nxt;
  poi_mul_t   mul_kind_r, mul_kind_nxt;

  logic               method_r, method_nxt;
  logic signed [31:0] init_x_r, init_x_nxt;
  logic signed [31:0] init_y_r, init_y_nxt;
  logic signed [31:0] init_h_r, init_h_nxt;
  logic signed [31:0] cur_x_r, cur_x_nxt;
  logic signed [31:0] cur_y_r, cur_y_nxt;
  logic signed [31:0] cur_h_r, cur_h_nxt;
  logic [47:0]        last_time_r, last_time_nxt;

  logic [47:0]        ts_r, ts_nxt;
  logic [31:0]        v_mag_r, v_mag_nxt;
  logic               v_neg_r, v_neg_nxt;
  logic [47:0]        dt_mag_r, dt_mag_nxt;
  logic               dt_neg_r, dt_neg_nxt;
  logic signed [34:0] dth_r, dth_nxt;

  logic [63:0]        mul_a_r, mul_a_nxt;
  logic [31:0]        mul_b_r, mul_b_nxt;
  logic               mul_neg_r, mul_neg_nxt;
  logic [95:0]        acc_r, acc_nxt;

  logic               ang_neg_r, ang_neg_nxt;
  logic [35:0]        rem_r, rem_nxt;
  logic [3:0]         red_k_r, red_k_nxt;

  logic signed [33:0] cx_r, cx_nxt;
  logic signed [33:0] cy_r, cy_nxt;
  logic signed [33:0] cz_r, cz_nxt;
  logic               flip_r, flip_nxt;
  logic [4:0]         cord_i_r, cord_i_nxt;

  logic [63:0]        d_mag_r, d_mag_nxt;
  logic               d_neg_r, d_neg_nxt;

  poi_out_t           out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic        in_fire;
  logic [47:0] diff;
  logic [47:0] diff_mag;
  logic [31:0] w_mag;
  logic [31:0] v_mag;

  logic [31:0] mul_half;
  logic [63:0] prod;
  logic [95:0] mul_q;
  logic [95:0] mul_lim;
  logic [63:0] mul_mag;
  logic [63:0] mul_res;

  logic signed [34:0] dth_half;
  logic signed [35:0] ang;
  logic [35:0]        ang_mag;
  logic [35:0]        trial;

  logic signed [29:0] r0, r1, r2;
  logic               r_flip;

  logic signed [33:0] cx_sh, cy_sh, atan_ext;
  logic signed [33:0] c_val, s_val;
  logic [33:0]        c_mag, s_mag;

  assign in_fire  = in_valid && in_ready;
  assign diff     = in_data.timestamp - last_time_r;
  assign diff_mag = diff[47] ? (48'd0 - diff) : diff;
  assign w_mag    = in_data.angular_velocity[31] ? (32'd0 - in_data.angular_velocity)
                                                 : in_data.angular_velocity;
  assign v_mag    = in_data.linear_velocity[31] ? (32'd0 - in_data.linear_velocity)
                                                : in_data.linear_velocity;

  // shared multiplier, low then high half of the wide operand
  assign mul_half = (state_r == S_MUL_HI) ? mul_a_r[63:32] : mul_a_r[31:0];
  assign prod     = 64'(mul_half) * 64'(mul_b_r);

  always_comb begin
    case (mul_kind_r)
      MK_DTH: begin
        mul_q   = acc_r >> 12;
        mul_lim = LIM_33;
      end
      MK_DIST: begin
        mul_q   = acc_r >> 20;
        mul_lim = LIM_62;
      end
      default: begin
        mul_q   = acc_r >> 30;
        mul_lim = LIM_33;
      end
    endcase
  end

  assign mul_mag = (mul_q > mul_lim) ? mul_lim[63:0] : mul_q[63:0];
  assign mul_res = mul_neg_r ? (64'd0 - mul_mag) : mul_mag;

  // midpoint angle, half step truncated toward zero
  assign dth_half = (dth_r + $signed({34'd0, dth_r[34]})) >>> 1;
  assign ang      = $signed({{4{cur_h_r[31]}}, cur_h_r})
                  + (method_r ? $signed({dth_half[34], dth_half}) : 36'sd0);
  assign ang_mag  = ang[35] ? 36'(-ang) : 36'(ang);
  assign trial    = TWO_PI_Q24 << red_k_r;

  // fold into [-pi/2, pi/2]
  always_comb begin
    r0 = (ang_neg_r && (rem_r != 36'd0)) ? (TWO_PI_R - $signed(rem_r[29:0]))
                                         : $signed(rem_r[29:0]);
    r1 = (r0 >= PI_R) ? (r0 - TWO_PI_R) : r0;
    r_flip = 1'b0;
    r2 = r1;
    if (r1 > HALF_PI_R) begin
      r2 = r1 - PI_R;
      r_flip = 1'b1;
    end else if (r1 < -HALF_PI_R) begin
      r2 = r1 + PI_R;
      r_flip = 1'b1;
    end
  end

  assign cx_sh    = cx_r >>> cord_i_r;
  assign cy_sh    = cy_r >>> cord_i_r;
  assign atan_ext = $signed({2'b00, atan_q30(cord_i_r)});
  assign c_val    = flip_r ? -cx_r : cx_r;
  assign s_val    = flip_r ? -cy_r : cy_r;
  assign c_mag    = c_val[33] ? 34'(-c_val) : 34'(c_val);
  assign s_mag    = s_val[33] ? 34'(-s_val) : 34'(s_val);

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    mul_kind_nxt  = mul_kind_r;
    method_nxt    = method_r;
    init_x_nxt    = init_x_r;
    init_y_nxt    = init_y_r;
    init_h_nxt    = init_h_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_h_nxt     = cur_h_r;
    last_time_nxt = last_time_r;
    ts_nxt        = ts_r;
    v_mag_nxt     = v_mag_r;
    v_neg_nxt     = v_neg_r;
    dt_mag_nxt    = dt_mag_r;
    dt_neg_nxt    = dt_neg_r;
    dth_nxt       = dth_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_neg_nxt   = mul_neg_r;
    acc_nxt       = acc_r;
    ang_neg_nxt   = ang_neg_r;
    rem_nxt       = rem_r;
    red_k_nxt     = red_k_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    flip_nxt      = flip_r;
    cord_i_nxt    = cord_i_r;
    d_mag_nxt     = d_mag_r;
    d_neg_nxt     = d_neg_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cfg_we) begin
      case (poi_reg_t'(cfg_index))
        REG_METHOD:       method_nxt = cfg_data[0];
        REG_INIT_X:       init_x_nxt = $signed(cfg_data);
        REG_INIT_Y:       init_y_nxt = $signed(cfg_data);
        REG_INIT_HEADING: init_h_nxt = $signed(cfg_data);
        default:          method_nxt = method_r;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (poi_op_t'(in_data.op))
            OP_SAMPLE: begin
              ts_nxt       = in_data.timestamp;
              v_mag_nxt    = v_mag;
              v_neg_nxt    = in_data.linear_velocity[31];
              dt_mag_nxt   = diff_mag;
              dt_neg_nxt   = diff[47];
              mul_a_nxt    = {16'd0, diff_mag};
              mul_b_nxt    = w_mag;
              mul_neg_nxt  = diff[47] ^ in_data.angular_velocity[31];
              mul_kind_nxt = MK_DTH;
              state_nxt    = S_MUL_LO;
            end
            OP_ZERO: begin
              cur_x_nxt = 32'sd0;
              cur_y_nxt = 32'sd0;
              cur_h_nxt = 32'sd0;
            end
            OP_START: begin
              cur_x_nxt     = init_x_r;
              cur_y_nxt     = init_y_r;
              cur_h_nxt     = init_h_r;
              last_time_nxt = in_data.timestamp;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MUL_LO: begin
        acc_nxt   = {32'd0, prod};
        state_nxt = S_MUL_HI;
      end
      S_MUL_HI: begin
        acc_nxt   = acc_r + {prod, 32'd0};
        state_nxt = S_MUL_FIN;
      end
      S_MUL_FIN: begin
        case (mul_kind_r)
          MK_DTH: begin
            dth_nxt   = $signed(mul_res[34:0]);
            state_nxt = S_ANG;
          end
          MK_DIST: begin
            d_mag_nxt    = mul_mag;
            d_neg_nxt    = mul_neg_r;
            mul_a_nxt    = mul_mag;
            mul_b_nxt    = c_mag[31:0];
            mul_neg_nxt  = mul_neg_r ^ c_val[33];
            mul_kind_nxt = MK_DX;
            state_nxt    = S_MUL_LO;
          end
          MK_DX: begin
            cur_x_nxt    = sat32($signed({{4{cur_x_r[31]}}, cur_x_r})
                                 + $signed(mul_res[35:0]));
            mul_a_nxt    = d_mag_r;
            mul_b_nxt    = s_mag[31:0];
            mul_neg_nxt  = d_neg_r ^ s_val[33];
            mul_kind_nxt = MK_DY;
            state_nxt    = S_MUL_LO;
          end
          default: begin
            cur_y_nxt     = sat32($signed({{4{cur_y_r[31]}}, cur_y_r})
                                  + $signed(mul_res[35:0]));
            cur_h_nxt     = sat32($signed({{4{cur_h_r[31]}}, cur_h_r})
                                  + $signed({dth_r[34], dth_r}));
            last_time_nxt = ts_r;
            state_nxt     = S_DONE;
          end
        endcase
      end
      S_ANG: begin
        rem_nxt     = ang_mag;
        ang_neg_nxt = ang[35];
        red_k_nxt   = RED_TOP;
        state_nxt   = S_RED;
      end
      S_RED: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
        end
        if (red_k_r == 4'd0) begin
          state_nxt = S_FOLD;
        end else begin
          red_k_nxt = red_k_r - 4'd1;
        end
      end
      S_FOLD: begin
        cx_nxt     = CORDIC_GAIN;
        cy_nxt     = 34'sd0;
        cz_nxt     = $signed({r2[27:0], 6'd0});
        flip_nxt   = r_flip;
        cord_i_nxt = 5'd0;
        state_nxt  = S_CORDIC;
      end
      S_CORDIC: begin
        if (!cz_r[33]) begin
          cx_nxt = cx_r - cy_sh;
          cy_nxt = cy_r + cx_sh;
          cz_nxt = cz_r - atan_ext;
        end else begin
          cx_nxt = cx_r + cy_sh;
          cy_nxt = cy_r - cx_sh;
          cz_nxt = cz_r + atan_ext;
        end
        if (cord_i_r == STEP_LAST) begin
          mul_a_nxt    = {16'd0, dt_mag_r};
          mul_b_nxt    = v_mag_r;
          mul_neg_nxt  = dt_neg_r ^ v_neg_r;
          mul_kind_nxt = MK_DIST;
          state_nxt    = S_MUL_LO;
        end else begin
          cord_i_nxt = cord_i_r + 5'd1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.pose_x  = cur_x_r;
          out_data_nxt.pose_y  = cur_y_r;
          out_data_nxt.heading = cur_h_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      method_r    <= 1'b0;
      init_x_r    <= 32'sd0;
      init_y_r    <= 32'sd0;
      init_h_r    <= 32'sd0;
      cur_x_r     <= 32'sd0;
      cur_y_r     <= 32'sd0;
      cur_h_r     <= 32'sd0;
      last_time_r <= 48'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      method_r    <= method_nxt;
      init_x_r    <= init_x_nxt;
      init_y_r    <= init_y_nxt;
      init_h_r    <= init_h_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      cur_h_r     <= cur_h_nxt;
      last_time_r <= last_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mul_kind_r <= mul_kind_nxt;
    ts_r       <= ts_nxt;
    v_mag_r    <= v_mag_nxt;
    v_neg_r    <= v_neg_nxt;
    dt_mag_r   <= dt_mag_nxt;
    dt_neg_r   <= dt_neg_nxt;
    dth_r      <= dth_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    mul_neg_r  <= mul_neg_nxt;
    acc_r      <= acc_nxt;
    ang_neg_r  <= ang_neg_nxt;
    rem_r      <= rem_nxt;
    red_k_r    <= red_k_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    cz_r       <= cz_nxt;
    flip_r     <= flip_nxt;
    cord_i_r   <= cord_i_nxt;
    d_mag_r    <= d_mag_nxt;
    d_neg_r    <= d_neg_nxt;
    out_data_r <= out_data_nxt;
  end

  `POI_ASSERT_NEXT(a_busy_after_sample,
                   in_valid && in_ready && (in_data.op == OP_SAMPLE),
                   !in_ready, "sample word did not hold off the input")
  `POI_ASSERT_NEXT(a_done_emits, (state_r == S_DONE) && (!out_valid_r || out_ready),
                   out_valid_r && (state_r == S_IDLE), "finished pose was not presented")
  `POI_ASSERT_NEXT(a_control_silent,
                   in_valid && in_ready && (in_data.op != OP_SAMPLE) && !out_valid_r,
                   !out_valid_r, "control word produced a result")
  `POI_ASSERT_SAME(a_cordic_index, state_r == S_CORDIC, cord_i_r <= STEP_LAST,
                   "rotation index past last step")

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// planar odometry integrator testbench
// drives op words through the valid/ready input and predicts every pose word
// with a cycle-free fixed-point copy of the euler and midpoint integrator,
// including the cordic and the saturating products; the pose words leaving the
// block are compared field by field against the predicted queue while both
// sides idle and stall at random and the registers move through several
// settings, extremes among them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import poi_pkg::*;

  localparam int ROT_STEPS      = 24;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 60;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam longint FULL_TURN    = 105414357;
  localparam longint HALF_TURN    = 52707179;
  localparam longint QUARTER_TURN = 26353589;
  localparam longint ROT_GAIN     = 64'h26DD3B6A;
  localparam longint unsigned LIM_STEP = 64'd1 << 33;
  localparam longint unsigned LIM_DIST = 64'd1 << 62;

  longint arctan_q30 [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  poi_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  poi_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_METHOD;
  logic [31:0] cfg_data = '0;

  // predictor copy of registers and pose
  bit                 rk_mode;
  logic signed [31:0] init_x, init_y, init_hdg;
  logic signed [31:0] pos_x, pos_y, hdg;
  logic [47:0]        prev_ts;

  poi_out_t    expected_poses [$];
  logic [47:0] ts_cursor = '0;
  bit          hold_req = 1'b0;
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          velocity_words = 0;
  int          poses_checked = 0;
  int          idle_count = 0;

  planar_odometry_integrator_unit #(
    .CORDIC_STEPS(ROT_STEPS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic signed [31:0] clamp_s32(input longint v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // (a*b) >> sh toward zero, magnitude clamped to lim
  function automatic longint scaled_mul(input longint a, input longint b, input int sh,
                                        input longint unsigned lim);
    logic [127:0] ma, mb, q;
    logic [63:0]  r;
    bit           neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -(128'(a)) : 128'(a);
    mb = (b < 0) ? -(128'(b)) : 128'(b);
    q = (ma * mb) >> sh;
    if (q > {64'd0, lim}) q = {64'd0, lim};
    r = q[63:0];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  function automatic void rotate_unit(input longint ang, output longint cos_q30,
                                      output longint sin_q30);
    longint unsigned mag;
    longint          r, x, y, z, sx, sy;
    bit              flip;
    mag = ang < 0 ? -ang : ang;
    r = mag % FULL_TURN;
    flip = 1'b0;
    if (ang < 0 && r != 0) r = FULL_TURN - r;
    if (r >= HALF_TURN) r -= FULL_TURN;
    if (r > QUARTER_TURN) begin
      r -= HALF_TURN;
      flip = 1'b1;
    end else if (r < -QUARTER_TURN) begin
      r += HALF_TURN;
      flip = 1'b1;
    end
    z = r * 64;
    x = ROT_GAIN;
    y = 0;
    for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (z >= 0) begin
        x -= sx;
        y += sy;
        z -= arctan_q30[i];
      end else begin
        x += sx;
        y -= sy;
        z += arctan_q30[i];
      end
    end
    cos_q30 = flip ? -x : x;
    sin_q30 = flip ? -y : y;
  endfunction

  function automatic void advance_pose(input poi_in_t wd);
    logic [47:0] diff;
    longint      dt, dth, ang, c, s, travel;
    poi_out_t    pose;
    case (wd.op)
      OP_ZERO: begin
        pos_x = '0;
        pos_y = '0;
        hdg = '0;
      end
      OP_START: begin
        pos_x = init_x;
        pos_y = init_y;
        hdg = init_hdg;
        prev_ts = wd.timestamp;
      end
      OP_SAMPLE: begin
        diff = wd.timestamp - prev_ts;
        dt = longint'($signed(diff));
        dth = scaled_mul(longint'(wd.angular_velocity), dt, 12, LIM_STEP);
        ang = longint'(hdg);
        if (rk_mode) ang += dth / 2;
        rotate_unit(ang, c, s);
        travel = scaled_mul(longint'(wd.linear_velocity), dt, 20, LIM_DIST);
        pos_x = clamp_s32(longint'(pos_x) + scaled_mul(travel, c, 30, LIM_STEP));
        pos_y = clamp_s32(longint'(pos_y) + scaled_mul(travel, s, 30, LIM_STEP));
        hdg = clamp_s32(longint'(hdg) + dth);
        prev_ts = wd.timestamp;
        pose.pose_x = pos_x;
        pose.pose_y = pos_y;
        pose.heading = hdg;
        expected_poses.push_back(pose);
        velocity_words++;
      end
      default: begin
      end
    endcase
  endfunction

  // ------------------------------------------------------------------ checking

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t ns: %s", $time, what);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_poses
    poi_out_t want;
    if (rst_n && out_valid && out_ready) begin
      poses_checked++;
      if (expected_poses.size() == 0) begin
        report_mismatch($sformatf("pose word %h with nothing expected", out_data));
      end else begin
        want = expected_poses.pop_front();
        if (out_data.pose_x !== want.pose_x)
          report_mismatch($sformatf("pose_x got %h expected %h", out_data.pose_x, want.pose_x));
        if (out_data.pose_y !== want.pose_y)
          report_mismatch($sformatf("pose_y got %h expected %h", out_data.pose_y, want.pose_y));
        if (out_data.heading !== want.heading)
          report_mismatch($sformatf("heading got %h expected %h", out_data.heading,
                                    want.heading));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // output side stall pattern, with a long hold-off on request
  initial begin : pose_sink
    int mode, mode_left, hold_left;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(40, 400);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= (mode_left % 5) != 0;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_word(input poi_in_t wd);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= wd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_pose(wd);
    words_sent++;
  endtask

  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    idle_input(0);
    while (expected_poses.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input poi_reg_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_METHOD:       rk_mode = val[0];
      REG_INIT_X:       init_x = val;
      REG_INIT_Y:       init_y = val;
      REG_INIT_HEADING: init_hdg = val;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input bit method, input logic [31:0] ix, iy, ih);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_METHOD, {31'd0, method});
    write_reg(REG_INIT_X, ix);
    write_reg(REG_INIT_Y, iy);
    write_reg(REG_INIT_HEADING, ih);
  endtask

  function automatic poi_in_t make_word(input logic [1:0] op, input logic [31:0] lin, rot,
                                        input logic [47:0] ts);
    poi_in_t wd;
    wd.op = op;
    wd.linear_velocity = lin;
    wd.angular_velocity = rot;
    wd.timestamp = ts;
    return wd;
  endfunction

  function automatic poi_in_t random_velocity_word();
    poi_in_t     wd;
    logic [63:0] r64;
    int          kind;
    kind = $urandom_range(0, 99);
    r64 = {$urandom, $urandom};
    wd.op = OP_SAMPLE;
    wd.linear_velocity = int'($urandom_range(0, 524288)) - 262144;
    wd.angular_velocity = int'($urandom_range(0, 524288)) - 262144;
    if (kind < 55) begin
      wd.timestamp = ts_cursor + $urandom_range(0, 1 << 18);
    end else if (kind < 70) begin
      wd.linear_velocity = int'($urandom) >>> $urandom_range(0, 31);
      wd.angular_velocity = int'($urandom) >>> $urandom_range(0, 31);
      wd.timestamp = ts_cursor + $urandom_range(0, 1 << 24);
    end else if (kind < 80) begin
      wd.linear_velocity = $urandom;
      wd.angular_velocity = $urandom;
      wd.timestamp = ts_cursor + $urandom_range(0, 1 << 16);
    end else if (kind < 88) begin
      wd.timestamp = ts_cursor - $urandom_range(1, 1 << 20);
    end else if (kind < 94) begin
      wd.linear_velocity = $urandom;
      wd.angular_velocity = $urandom;
      wd.timestamp = r64[47:0];
    end else begin
      wd.timestamp = ts_cursor;
    end
    ts_cursor = wd.timestamp;
    return wd;
  endfunction

  function automatic poi_in_t random_control_word(input logic [1:0] op);
    logic [63:0] r64;
    r64 = {$urandom, $urandom};
    if (op == OP_START) begin
      ts_cursor = $urandom_range(0, 1) ? r64[47:0] : ts_cursor + $urandom_range(0, 1 << 20);
      return make_word(op, $urandom, $urandom, ts_cursor);
    end
    return make_word(op, $urandom, $urandom, r64[47:0]);
  endfunction

  // ------------------------------------------------------------------ tests

  task automatic test_directed_extremes(input bit method, input logic [31:0] ix, iy, ih);
    logic [47:0] t;
    set_config(method, ix, iy, ih);
    t = '0;
    send_word(make_word(OP_START, 32'h0, 32'h0, t));
    t = 48'd1 << 20;
    send_word(make_word(OP_SAMPLE, 32'h0001_0000, 32'h0000_8000, t));
    send_word(make_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, t));
    t = t + 48'h7FFF_FFFF_FFFF;
    send_word(make_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, t));
    t = t + 48'h8000_0000_0000;
    send_word(make_word(OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, t));
    t = t + 48'h8000_0000_0000;
    send_word(make_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, t));
    // zero keeps the previous time
    send_word(make_word(OP_ZERO, 32'h1234_5678, 32'h8765_4321, t + 48'd12345));
    t = t + 48'h1_9999;
    send_word(make_word(OP_SAMPLE, 32'hFFFF_0000, 32'hFFFD_0000, t));
    send_word(make_word(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
    t = 48'hFFFF_FFFF_FFFF;
    send_word(make_word(OP_SAMPLE, 32'h0, 32'h0, t));
    t = '0;
    send_word(make_word(OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, t));
    t = 48'hABCD_0000_1234;
    send_word(make_word(OP_START, 32'h0, 32'h0, t));
    send_word(make_word(OP_SAMPLE, 32'h0001_0000, 32'h0, t + (48'd1 << 20)));
    ts_cursor = t + (48'd1 << 20);
  endtask

  task automatic test_random_walk(input bit method, input int n, input logic [31:0] ix, iy,
                                  ih);
    poi_in_t wd;
    int      sent, burst, pick;
    set_config(method, ix, iy, ih);
    send_word(random_control_word(OP_START));
    sent = 0;
    burst = 0;
    while (sent < n) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) begin
          idle_input($urandom_range(1, 30));
        end else if ($urandom_range(0, 19) == 0) begin
          wait_drained();
        end
      end
      burst--;
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        wd = random_control_word(OP_ZERO);
      end else if (pick < 9) begin
        wd = random_control_word(OP_START);
      end else if (pick < 12) begin
        wd = random_control_word(OP_UNUSED);
      end else begin
        wd = random_velocity_word();
      end
      send_word(wd);
      if (wd.op != OP_UNUSED) sent++;
    end
  endtask

  // output held off while words keep coming, so the input side has to stall
  task automatic test_backpressure();
    wait_drained();
    hold_req = 1'b1;
    repeat (8) send_word(random_velocity_word());
  endtask

  task automatic test_drain_pause();
    repeat (6) send_word(random_velocity_word());
    wait_drained();
    repeat (6) send_word(random_velocity_word());
  endtask

  initial begin
    rk_mode = 1'b0;
    init_x = '0;
    init_y = '0;
    init_hdg = '0;
    pos_x = '0;
    pos_y = '0;
    hdg = '0;
    prev_ts = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_extremes(1'b0, 32'h7FFF_0000, 32'h8001_0000, 32'(HALF_TURN));
    test_directed_extremes(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'(-QUARTER_TURN));
    test_random_walk(1'b0, 450, 32'h0, 32'h0, 32'h0);
    test_random_walk(1'b1, 450, $urandom, $urandom, $urandom);
    test_backpressure();
    test_random_walk(1'b0, 300, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    test_drain_pause();
    test_random_walk(1'b1, 300, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    test_random_walk(1'b1, 300, $urandom, $urandom, $urandom >>> 4);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_poses.size() != 0)
      report_mismatch($sformatf("%0d pose words never arrived", expected_poses.size()));
    $display("covered %0d input words, %0d velocity words, %0d pose words compared",
             words_sent, velocity_words, poses_checked);
    $display("both step methods, saturating extremes, wrapped and negative time steps, stalls");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
